// File: rtl/core/gmc_pkg.sv
// Package for the gate motor controller: state codes and beat payload types.
// Used by gate_motor_controller_top.
package gmc_pkg;

  // Width of the reported state code and of the run limit register.
  localparam int unsigned StateW = 4;
  localparam int unsigned LimitW = 16;
  localparam logic [LimitW-1:0] LimitReset = 16'd1800;

  // Gate states, encoded as the reported state code.
  typedef enum logic [StateW-1:0] {
    ST_START     = 4'd0,
    ST_UNKNOWN   = 4'd1,
    ST_CLOSING   = 4'd2,
    ST_OPENING   = 4'd3,
    ST_CLOSED    = 4'd4,
    ST_OPEN      = 4'd5,
    ST_OBSTACLE  = 4'd6,
    ST_USER_STOP = 4'd7,
    ST_ERROR     = 4'd8
  } gate_state_e;

  // One tick of sampled switches and buttons.
  typedef struct packed {
    logic open_limit;
    logic closed_limit;
    logic beam_blocked;
    logic close_button;
    logic open_button;
    logic stop_button;
    logic fault_clear;
    logic push_level;
  } gmc_tick_t;

  // Drives and state code produced for one tick.
  typedef struct packed {
    logic              motor_close;
    logic              motor_open;
    logic              lamp_on;
    logic              horn_on;
    logic [StateW-1:0] state_code;
  } gmc_result_t;

endpackage

// File: rtl/core/gmc_in_if.sv
// Input channel of the gate motor controller: one tick of switch samples per beat.
// Depends on nothing; plain valid/ready handshake.
interface gmc_in_if;
  logic valid;
  logic ready;
  logic open_limit;
  logic closed_limit;
  logic beam_blocked;
  logic close_button;
  logic open_button;
  logic stop_button;
  logic fault_clear;
  logic push_level;

  modport source (
    output valid, open_limit, closed_limit, beam_blocked, close_button,
           open_button, stop_button, fault_clear, push_level,
    input  ready
  );

  modport sink (
    input  valid, open_limit, closed_limit, beam_blocked, close_button,
           open_button, stop_button, fault_clear, push_level,
    output ready
  );
endinterface

// File: rtl/core/gmc_out_if.sv
// Output channel of the gate motor controller: drives and state code per beat.
// Depends on nothing; plain valid/ready handshake.
interface gmc_out_if;
  logic       valid;
  logic       ready;
  logic       motor_close;
  logic       motor_open;
  logic       lamp_on;
  logic       horn_on;
  logic [3:0] state_code;

  modport source (
    output valid, motor_close, motor_open, lamp_on, horn_on, state_code,
    input  ready
  );

  modport sink (
    input  valid, motor_close, motor_open, lamp_on, horn_on, state_code,
    output ready
  );
endinterface

// File: rtl/core/gate_motor_controller_top.sv
// Gate motor controller top level: nine-state gate sequencer with run timer.
// Depends on gmc_pkg, gmc_in_if and gmc_out_if.
//
//   Channel  Direction  Handshake          Beat contents
//   in_i     in         valid/ready        limit switches, photocell, buttons
//   out_o    out        valid/ready        motor drives, lamp, buzzer, state
//   cfg      in         cfg_we_i (write)   run_limit_ticks on cfg_wdata_i
//
// A tick is registered on acceptance and its result is loaded into the output
// register when that register can load; one tick is taken every cycle while
// the output is not stalled. The sequencer state advances when a tick moves
// into the output register. A stalled output holds its beat; the input register
// then fills and ready falls until the output drains. Reset clears state, the
// run timer and both valid flags, and loads the run limit with 1800.
module gate_motor_controller_top
  import gmc_pkg::*;
#(
  parameter int unsigned RUN_COUNT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_wdata_i,
  gmc_in_if.sink            in_i,
  gmc_out_if.source         out_o
);

  localparam int unsigned CmpW = (RUN_COUNT_BITS > LimitW) ? RUN_COUNT_BITS : LimitW;

  logic [LimitW-1:0]         limit_q;
  logic                      in_valid_q;
  gmc_tick_t                 tick_q;
  logic                      out_valid_q;
  gmc_result_t               res_q, res_d;
  gate_state_e               state_q, state_d;
  logic                      push_prev_q;
  logic [RUN_COUNT_BITS-1:0] count_q, count_d, count_inc;
  logic                      armed_q, armed_d;
  logic                      lwc_q, lwc_d;
  logic                      advance, process, push_edge, over_limit;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Handshake: the input register empties whenever the output register can load.
  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || advance;
  assign process    = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      tick_q.open_limit   <= in_i.open_limit;
      tick_q.closed_limit <= in_i.closed_limit;
      tick_q.beam_blocked <= in_i.beam_blocked;
      tick_q.close_button <= in_i.close_button;
      tick_q.open_button  <= in_i.open_button;
      tick_q.stop_button  <= in_i.stop_button;
      tick_q.fault_clear  <= in_i.fault_clear;
      tick_q.push_level   <= in_i.push_level;
    end
  end

  // Run timer: saturating increment and limit compare.
  assign count_inc  = (count_q != {RUN_COUNT_BITS{1'b1}}) ? count_q + 1'b1 : count_q;
  assign over_limit = CmpW'(count_inc) > CmpW'(limit_q);
  assign push_edge  = tick_q.push_level && !push_prev_q;

  // Next state and drives for the tick in the input register.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    armed_d = armed_q;
    lwc_d   = lwc_q;
    res_d   = '0;
    res_d.state_code = state_q;
    case (state_q)
      ST_START: begin
        armed_d = 1'b0;
        count_d = '0;
        state_d = ST_UNKNOWN;
      end
      ST_UNKNOWN: begin
        res_d.motor_close = 1'b1;
        res_d.horn_on     = 1'b1;
        if (!armed_q) begin
          armed_d = 1'b1;
          count_d = '0;
        end else if (tick_q.closed_limit) begin
          state_d = ST_CLOSED;
          armed_d = 1'b0;
        end else begin
          count_d = count_inc;
          if (over_limit) state_d = ST_ERROR;
        end
      end
      ST_CLOSING: begin
        res_d.motor_close = 1'b1;
        res_d.lamp_on     = 1'b1;
        res_d.horn_on     = 1'b1;
        lwc_d = 1'b1;
        if (!armed_q) begin
          armed_d = 1'b1;
          count_d = '0;
        end else if (tick_q.closed_limit) begin
          state_d = ST_CLOSED;
          armed_d = 1'b0;
        end else if (tick_q.beam_blocked) begin
          state_d = ST_OBSTACLE;
          armed_d = 1'b0;
        end else if (push_edge || tick_q.stop_button) begin
          state_d = ST_USER_STOP;
          armed_d = 1'b0;
        end else begin
          count_d = count_inc;
          if (over_limit) state_d = ST_ERROR;
        end
      end
      ST_OPENING: begin
        res_d.motor_open = 1'b1;
        res_d.lamp_on    = 1'b1;
        res_d.horn_on    = 1'b1;
        lwc_d = 1'b0;
        if (!armed_q) begin
          armed_d = 1'b1;
          count_d = '0;
        end else if (tick_q.open_limit) begin
          state_d = ST_OPEN;
          armed_d = 1'b0;
        end else if (push_edge || tick_q.stop_button) begin
          state_d = ST_USER_STOP;
          armed_d = 1'b0;
        end else begin
          count_d = count_inc;
          if (over_limit) state_d = ST_ERROR;
        end
      end
      ST_CLOSED: begin
        if (push_edge || tick_q.open_button) state_d = ST_OPENING;
      end
      ST_OPEN: begin
        if (push_edge || tick_q.close_button) state_d = ST_CLOSING;
      end
      ST_OBSTACLE: begin
        res_d.lamp_on = 1'b1;
        if (push_edge || tick_q.open_button) state_d = ST_OPENING;
      end
      ST_USER_STOP: begin
        res_d.lamp_on = 1'b1;
        // Reverse the direction of the last motor run.
        if (push_edge) state_d = lwc_q ? ST_OPENING : ST_CLOSING;
      end
      ST_ERROR: begin
        res_d.lamp_on = 1'b1;
        res_d.horn_on = 1'b1;
        if (tick_q.fault_clear) state_d = ST_START;
      end
      default: begin
        state_d = ST_START;
      end
    endcase
  end

  // Sequencer state, updated as each tick moves to the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_START;
      push_prev_q <= 1'b0;
      count_q     <= '0;
      armed_q     <= 1'b0;
      lwc_q       <= 1'b0;
    end else if (process) begin
      state_q     <= state_d;
      push_prev_q <= tick_q.push_level;
      count_q     <= count_d;
      armed_q     <= armed_d;
      lwc_q       <= lwc_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= process || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.motor_close = res_q.motor_close;
  assign out_o.motor_open  = res_q.motor_open;
  assign out_o.lamp_on     = res_q.lamp_on;
  assign out_o.horn_on     = res_q.horn_on;
  assign out_o.state_code  = res_q.state_code;

endmodule
